// ===== hdl/ezr_pkg.sv =====
// ----------------------------------------------------------------------------
// ezr_pkg - shared constants, types and arithmetic helpers
// holds the arctangent table, the cordic word types and the q30 multiply helper
// ----------------------------------------------------------------------------
`default_nettype none
package ezr_pkg;
	localparam int OUT_FRAC_BITS = 14;
	localparam int OUT_W = OUT_FRAC_BITS + 2;
	localparam int ANG_W = 16;
	localparam int STEPS = 30;
	localparam int FRAC = 30;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] GAIN_INIT = 34'sd652032874;

	typedef logic signed [CW-1:0] cw_t;

	typedef struct packed {
		cw_t x;
		cw_t y;
		cw_t z;
		logic neg;
	} crd_t;

	function automatic cw_t atan_lut(input logic [4:0] i);
		case (i)
			5'd0: atan_lut = 34'h20000000;
			5'd1: atan_lut = 34'h12E4051D;
			5'd2: atan_lut = 34'h09FB385B;
			5'd3: atan_lut = 34'h051111D4;
			5'd4: atan_lut = 34'h028B0D43;
			5'd5: atan_lut = 34'h0145D7E1;
			5'd6: atan_lut = 34'h00A2F61E;
			5'd7: atan_lut = 34'h00517C55;
			5'd8: atan_lut = 34'h0028BE53;
			5'd9: atan_lut = 34'h00145F2E;
			5'd10: atan_lut = 34'h000A2F98;
			5'd11: atan_lut = 34'h000517CC;
			5'd12: atan_lut = 34'h00028BE6;
			5'd13: atan_lut = 34'h000145F3;
			5'd14: atan_lut = 34'h0000A2F9;
			5'd15: atan_lut = 34'h0000517C;
			5'd16: atan_lut = 34'h000028BE;
			5'd17: atan_lut = 34'h0000145F;
			5'd18: atan_lut = 34'h00000A2F;
			5'd19: atan_lut = 34'h00000517;
			5'd20: atan_lut = 34'h0000028B;
			5'd21: atan_lut = 34'h00000145;
			5'd22: atan_lut = 34'h000000A2;
			5'd23: atan_lut = 34'h00000051;
			5'd24: atan_lut = 34'h00000028;
			5'd25: atan_lut = 34'h00000014;
			5'd26: atan_lut = 34'h0000000A;
			5'd27: atan_lut = 34'h00000005;
			5'd28: atan_lut = 34'h00000002;
			5'd29: atan_lut = 34'h00000001;
			default: atan_lut = '0;
		endcase
	endfunction

	// q30 product, round half up
	function automatic cw_t qmul(input cw_t a, input cw_t b);
		logic signed [2*CW-1:0] p;
		p = 68'(a) * 68'(b) + (68'sd1 <<< (FRAC - 1));
		qmul = cw_t'(p >>> FRAC);
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input cw_t v);
		cw_t r;
		cw_t one;
		one = cw_t'(1) <<< OUT_FRAC_BITS;
		r = (v + (cw_t'(1) <<< (FRAC - OUT_FRAC_BITS - 1))) >>> (FRAC - OUT_FRAC_BITS);
		if (r > one) r = one;
		if (r < -one) r = -one;
		to_out = r[OUT_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== hdl/euler_zxy_to_rotation_matrix_top.sv =====
// ----------------------------------------------------------------------------
// euler_zxy_to_rotation_matrix_top - zxy euler angles to rotation matrix
// pipelined cordic plus product stages giving R = Rz(yaw)*Rx(roll)*Ry(pitch)
// ----------------------------------------------------------------------------
// usage
//   s_axis: one request per transfer, tdata = {yaw, pitch, roll} (roll lowest),
//   each a 16-bit binary angle with 32768 units to pi
//   m_axis: one result per request, tdata = nine 16-bit q1.14 entries,
//   m00 lowest up to m22, each saturated to plus or minus 1.0
//   throughput: one request per cycle while the receiver does not stall, set by
//   the fully pipelined cordic (one rotation step per stage) and the product stages
//   stages from acceptance to m_axis_tvalid: 1 fold register, 30 cordic steps,
//   2 product stages, 1 output register
//   the whole pipe advances as one: it moves when the output register is
//   empty or being taken, so a stalled receiver freezes every stage and no
//   request is lost or repeated; s_axis_tready follows that same enable
//   reset clears the valid bits only; data registers are left untouched
// ----------------------------------------------------------------------------
`default_nettype none
module euler_zxy_to_rotation_matrix_top import ezr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [47:0] s_axis_tdata, // roll, pitch, yaw
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [143:0] m_axis_tdata // m00, m01, m02, m10, m11, m12, m20, m21, m22
);
	localparam int DEPTH = STEPS + 4;

	logic en;
	logic [DEPTH-1:0] vld_q;
	cw_t sr, cr, sp, cp, sy, cy;

	// sine/cosine and their stage-one partners
	cw_t sr_s2, cr_s2, sp_s2, cp_s2, sy_s2, cy_s2;
	cw_t srsp_s2, srcp_s2;
	// stage three: the second products and a copy of the roll sine
	cw_t cpcy_s3, srspsy_s3, crsy_s3, spcy_s3, srcpsy_s3, cpsy_s3, srspcy_s3;
	cw_t crcy_s3, spsy_s3, srcpcy_s3, crsp_s3, crcp_s3, sr_s3;
	logic [143:0] out_q;

	// whole pipe moves together; output register empty or drained
	assign en = !vld_q[DEPTH-1] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	ezr_cordic u_roll (.clk(clk), .en(en), .angle(s_axis_tdata[15:0]),
		.sin_o(sr), .cos_o(cr));
	ezr_cordic u_pitch (.clk(clk), .en(en), .angle(s_axis_tdata[31:16]),
		.sin_o(sp), .cos_o(cp));
	ezr_cordic u_yaw (.clk(clk), .en(en), .angle(s_axis_tdata[47:32]),
		.sin_o(sy), .cos_o(cy));

	// first products: roll sine against pitch terms
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= sr; cr_s2 <= cr; sp_s2 <= sp;
			cp_s2 <= cp; sy_s2 <= sy; cy_s2 <= cy;
			srsp_s2 <= qmul(sr, sp);
			srcp_s2 <= qmul(sr, cp);
		end
	end

	// second products, one multiply each
	always_ff @(posedge clk) begin
		if (en) begin
			cpcy_s3 <= qmul(cp_s2, cy_s2);
			srspsy_s3 <= qmul(srsp_s2, sy_s2);
			crsy_s3 <= qmul(cr_s2, sy_s2);
			spcy_s3 <= qmul(sp_s2, cy_s2);
			srcpsy_s3 <= qmul(srcp_s2, sy_s2);
			cpsy_s3 <= qmul(cp_s2, sy_s2);
			srspcy_s3 <= qmul(srsp_s2, cy_s2);
			crcy_s3 <= qmul(cr_s2, cy_s2);
			spsy_s3 <= qmul(sp_s2, sy_s2);
			srcpcy_s3 <= qmul(srcp_s2, cy_s2);
			crsp_s3 <= qmul(cr_s2, sp_s2);
			crcp_s3 <= qmul(cr_s2, cp_s2);
			sr_s3 <= sr_s2;
		end
	end

	// sums, rounding to q1.14 and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			out_q[15:0] <= to_out(cpcy_s3 - srspsy_s3);
			out_q[31:16] <= to_out(-crsy_s3);
			out_q[47:32] <= to_out(spcy_s3 + srcpsy_s3);
			out_q[63:48] <= to_out(cpsy_s3 + srspcy_s3);
			out_q[79:64] <= to_out(crcy_s3);
			out_q[95:80] <= to_out(spsy_s3 - srcpcy_s3);
			out_q[111:96] <= to_out(-crsp_s3);
			out_q[127:112] <= to_out(sr_s3);
			out_q[143:128] <= to_out(crcp_s3);
		end
	end

	assign m_axis_tvalid = vld_q[DEPTH-1];
	assign m_axis_tdata = out_q;

	// a stalled result holds its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// ready only when output drains
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("request taken while pipe frozen");
	// an accepted request sets the valid bit of the first stage
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_q[0])
		else $error("accepted request lost its valid bit");
endmodule
`default_nettype wire

// ===== hdl/ezr_cordic.sv =====
// ----------------------------------------------------------------------------
// ezr_cordic - pipelined sine/cosine unit
// a fold register, then one rotation step per stage, giving q30 results
// ----------------------------------------------------------------------------
`default_nettype none
module ezr_cordic import ezr_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire logic [ANG_W-1:0] angle,
	output cw_t sin_o,
	output cw_t cos_o
);
	crd_t stg_s1 [STEPS+1];
	logic [31:0] a_full;
	logic [31:0] a_fold;
	logic fold;

	// fold the outer half turn onto the inner one
	assign a_full = {angle, 16'h0000};
	assign fold = a_full[31] ^ a_full[30];
	assign a_fold = fold ? a_full + 32'h80000000 : a_full;

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s1[0].x <= GAIN_INIT;
			stg_s1[0].y <= '0;
			stg_s1[0].z <= cw_t'($signed(a_fold));
			stg_s1[0].neg <= fold;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				stg_s1[i+1].neg <= stg_s1[i].neg;
				if (!stg_s1[i].z[CW-1]) begin
					stg_s1[i+1].x <= stg_s1[i].x - (stg_s1[i].y >>> i);
					stg_s1[i+1].y <= stg_s1[i].y + (stg_s1[i].x >>> i);
					stg_s1[i+1].z <= stg_s1[i].z - atan_lut(5'(i));
				end else begin
					stg_s1[i+1].x <= stg_s1[i].x + (stg_s1[i].y >>> i);
					stg_s1[i+1].y <= stg_s1[i].y - (stg_s1[i].x >>> i);
					stg_s1[i+1].z <= stg_s1[i].z + atan_lut(5'(i));
				end
			end
		end
	end

	assign sin_o = stg_s1[STEPS].neg ? -stg_s1[STEPS].y : stg_s1[STEPS].y;
	assign cos_o = stg_s1[STEPS].neg ? -stg_s1[STEPS].x : stg_s1[STEPS].x;
endmodule
`default_nettype wire
